@@ src/bda_pkg.sv @@
// Shared constants and types for the binary to decimal ASCII converter.
package bda_pkg;

  localparam int MAX_DIGITS  = 10;
  localparam int DIG_IDX_W   = $clog2(MAX_DIGITS);
  localparam int VALUE_W     = 31;
  localparam int DIGIT_W     = 4;
  localparam int CHAR_W      = 6;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 8;

  // Exact quotient by ten for any dividend below 2**32: (x * RECIP10) >> RECIP10_SHIFT.
  localparam int RECIP10_W     = 32;
  localparam logic [RECIP10_W-1:0] RECIP10 = 32'hCCCC_CCCD;
  localparam int RECIP10_SHIFT = 35;
  localparam int PROD_W        = VALUE_W + RECIP10_W;
  localparam int QUOT_W        = PROD_W - RECIP10_SHIFT;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_EMIT
  } bda_state_t;

endpackage

@@ src/bda_div10.sv @@
// Divide-by-ten unit: registered reciprocal product, then quotient and remainder.
module bda_div10
  import bda_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  logic [VALUE_W-1:0] dividend,
  output logic [QUOT_W-1:0]  quotient,
  output logic [DIGIT_W-1:0] remainder
);

  logic [VALUE_W-1:0] dvd;
  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] times_ten;

  // Hold the operand and its reciprocal product.
  always_ff @(posedge clk) begin
    if (load) begin
      dvd  <= dividend;
      prod <= PROD_W'(dividend) * PROD_W'(RECIP10);
    end
  end

  assign quotient  = prod[PROD_W-1:RECIP10_SHIFT];
  assign times_ten = (VALUE_W'(quotient) << 3) + (VALUE_W'(quotient) << 1);
  // True remainder is below ten, so four bits of the difference suffice.
  assign remainder = DIGIT_W'(dvd - times_ten);

endmodule

@@ src/binary_to_decimal_ascii.sv @@
// Top level: converts an unsigned binary value into ASCII decimal digit words.
//
// Input channel (s_axis_*): one word per value. s_axis_tdata carries the
// 31-bit value, s_axis_tuser the two-digit mode flag. Mode 0 gives the
// fewest digits with no leading zeros (zero gives "0"); mode 1 gives
// exactly the tens and units digits.
// Output channel (m_axis_*): one word per digit, most significant first.
// m_axis_tdata carries the ASCII code, m_axis_tlast marks the units digit.
//
// Timing: an accepted value is split into digits by one shared divide-by-
// ten unit, one digit at a time (reciprocal multiply, then remainder).
// Once all digits of a value are converted, they leave at one per cycle
// while the receiver takes them. s_axis_tready is high only while the
// converter is idle; the final digit may still wait in the output
// register while the next value is accepted.
// Reset: clears the sequencer and the output valid; the digit store needs
// no reset. When the receiver stalls, the current digit word holds and
// the sequencer waits.
module binary_to_decimal_ascii
  import bda_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [30:0] value, [31] zero
  input  logic                  s_axis_tuser,   // [0] two_digit_mode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [5:0] digit_char, [7:6] zero
  output logic                  m_axis_tlast    // last_digit
);

  bda_state_t state, state_next;

  logic [VALUE_W-1:0]   value;
  logic                 fixed_mode;
  logic [DIG_IDX_W-1:0] digit_idx;
  logic [DIGIT_W-1:0]   digits [MAX_DIGITS];

  logic [CHAR_W-1:0]    out_char;
  logic                 out_last;

  logic [QUOT_W-1:0]    quotient;
  logic [DIGIT_W-1:0]   remainder;

  logic in_accept;
  logic div_load;
  logic conv_done;
  logic out_load;

  bda_div10 u_div10 (
    .clk       (clk),
    .load      (div_load),
    .dividend  (value),
    .quotient  (quotient),
    .remainder (remainder)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign div_load      = (state == ST_MUL);

  // Fixed mode stops after the tens digit; free mode stops when the
  // quotient runs out or the digit store is full.
  assign conv_done = fixed_mode ? (digit_idx == DIG_IDX_W'(1))
                                : ((quotient == '0) ||
                                   (digit_idx == DIG_IDX_W'(MAX_DIGITS - 1)));

  // Load a new digit word when the output register is empty or being taken.
  assign out_load = (state == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_accept) state_next = ST_MUL;
      ST_MUL:  state_next = ST_SUB;
      ST_SUB:  state_next = conv_done ? ST_EMIT : ST_MUL;
      ST_EMIT: if (out_load && (digit_idx == '0)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the value, then replace it by each quotient; count digits up
  // while converting and down while emitting.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      value      <= s_axis_tdata[VALUE_W-1:0];
      fixed_mode <= s_axis_tuser;
      digit_idx  <= '0;
    end else if (state == ST_SUB) begin
      digits[digit_idx] <= remainder;
      value             <= VALUE_W'(quotient);
      if (!conv_done) begin
        digit_idx <= digit_idx + DIG_IDX_W'(1);
      end
    end else if (out_load && (digit_idx != '0)) begin
      digit_idx <= digit_idx - DIG_IDX_W'(1);
    end
  end

  // Output register: hold the word until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char <= ASCII_ZERO + CHAR_W'(digits[digit_idx]);
      out_last <= (digit_idx == '0);
    end
  end

  assign m_axis_tdata = {(OUT_DATA_W - CHAR_W)'(0), out_char};
  assign m_axis_tlast = out_last;

endmodule

@@ tb/bda_digit_checker.sv @@
`timescale 1ns / 100ps
// Converter checker: watches both channels, predicts the digit words and compares them.
module bda_digit_checker
  import bda_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [30:0] value, [31] zero
  input  logic                  s_axis_tuser,   // [0] two_digit_mode
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // [5:0] digit_char, [7:6] zero
  input  logic                  m_axis_tlast,   // last_digit
  output int                    failures,
  output int                    pending
);

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
  } digit_word_t;

  digit_word_t digit_q [$];
  digit_word_t seen;
  digit_word_t want;
  int          fail_cnt = 0;

  // Split a value into decimal digits and queue their ASCII words, most
  // significant first; fixed mode keeps only tens and units.
  task automatic predict_digits(input logic [VALUE_W-1:0] value, input logic two_digit);
    logic [DIGIT_W-1:0] digs [MAX_DIGITS];
    logic [VALUE_W-1:0] rest;
    int                 natural;
    int                 count;
    int                 k;
    digit_word_t        w;
    rest    = value;
    natural = 1;
    for (k = 0; k < MAX_DIGITS; k++) begin
      digs[k] = DIGIT_W'(rest % 10);
      rest    = VALUE_W'(rest / 10);
      if (rest != 0) natural = k + 2;
    end
    if (two_digit) begin
      count = 2;
    end else begin
      count = (natural > MAX_DIGITS) ? MAX_DIGITS : natural;
    end
    for (k = count - 1; k >= 0; k--) begin
      w.digit_char = ASCII_ZERO + CHAR_W'(digs[k]);
      w.last_digit = (k == 0);
      digit_q.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      // Compare the outgoing word before queuing the value taken at this edge.
      if (m_axis_tvalid && m_axis_tready) begin
        seen.digit_char = m_axis_tdata[CHAR_W-1:0];
        seen.last_digit = m_axis_tlast;
        if (digit_q.size() == 0) begin
          $error("digit word 0x%0h arrived with no digit expected", m_axis_tdata);
          fail_cnt++;
        end else begin
          want = digit_q.pop_front();
          if (seen.digit_char !== want.digit_char) begin
            $error("digit_char mismatch: expected %0d, actual %0d",
                   want.digit_char, seen.digit_char);
            fail_cnt++;
          end
          if (seen.last_digit !== want.last_digit) begin
            $error("last_digit mismatch: expected %0d, actual %0d",
                   want.last_digit, seen.last_digit);
            fail_cnt++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_digits(s_axis_tdata[VALUE_W-1:0], s_axis_tuser);
      end
    end
    failures <= fail_cnt;
    pending  <= digit_q.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Converter bench top: clock, reset, value stimulus, receiver stalls and verdict.
module testbench;
  import bda_pkg::*;

  localparam int RANDOM_VALUES = 360;
  localparam int QUIET_TAIL    = 40;   // last values sent with no idling on either side
  localparam int HOLD_CYCLES   = 300;  // long receiver hold-off to back up the input
  localparam int DRAIN_CYCLES  = 64;   // extra drain time after the checker queue empties
  localparam longint VALUE_MAX = 64'd2147483647;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;    // [30:0] value, [31] zero
  logic                  s_axis_tuser  = 1'b0;  // [0] two_digit_mode
  logic                  m_axis_tready = 1'b0;
  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic [OUT_DATA_W-1:0] m_axis_tdata;          // [5:0] digit_char, [7:6] zero
  logic                  m_axis_tlast;          // last_digit

  int failures;
  int pending;

  // Flags from the sender to the receiver process.
  bit hold_request = 1'b0;
  bit quiet        = 1'b0;

  binary_to_decimal_ascii dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  bda_digit_checker digit_monitor (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .failures      (failures),
    .pending       (pending)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offer one value word and hold it until the block takes it. Called at a
  // rising edge; returns at the edge of the handshake, so the caller drives
  // the next word or drops valid there with a single assignment.
  task automatic send_value(input logic [VALUE_W-1:0] value, input logic two_digit);
    // Insert a random idle burst ahead of the word, except in the quiet tail.
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, value};
    s_axis_tuser  <= two_digit;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Receiver: random stall and ready bursts, one long hold-off once asked,
  // steady ready in the quiet tail.
  initial begin
    bit held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (quiet) begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end else if (hold_request && !held) begin
        // Hold off long enough for the converter to fill and stall its input.
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int                 n_digits;
    longint             lo;
    longint             hi;
    logic [VALUE_W-1:0] value;
    logic               two_digit;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero in both modes, small values in fixed mode get a leading
    // zero, large values in fixed mode drop high digits, digit-count edges,
    // the ten-digit range up to the field maximum, alternating bit patterns.
    send_value(31'd0, 1'b0);
    send_value(31'd0, 1'b1);
    send_value(31'd5, 1'b1);
    send_value(31'd5, 1'b0);
    send_value(31'd1, 1'b0);
    send_value(31'd9, 1'b0);
    send_value(31'd10, 1'b0);
    send_value(31'd10, 1'b1);
    send_value(31'd99, 1'b0);
    send_value(31'd99, 1'b1);
    send_value(31'd100, 1'b0);
    send_value(31'd100, 1'b1);
    send_value(31'd12345, 1'b1);
    send_value(31'd999999999, 1'b0);
    send_value(31'd1000000000, 1'b0);
    send_value(31'd1000000000, 1'b1);
    send_value(31'd1234567890, 1'b0);
    send_value(31'd2147483647, 1'b0);
    send_value(31'd2147483647, 1'b1);
    send_value(31'h2AAA_AAAA, 1'b0);
    send_value(31'h5555_5555, 1'b0);
    send_value(31'h5555_5555, 1'b1);

    // Ask for the long receiver hold-off while values keep coming.
    hold_request = 1'b1;

    // Random: mostly values of a chosen digit length so every count shows up,
    // the rest spread over the whole 31-bit field.
    for (int i = 0; i < RANDOM_VALUES; i++) begin
      if (i >= RANDOM_VALUES - QUIET_TAIL) quiet = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        value = VALUE_W'($urandom());
      end else begin
        n_digits = $urandom_range(1, MAX_DIGITS);
        lo = (n_digits == 1) ? 0 : 1;
        repeat (n_digits - 1) lo = lo * 10;
        hi = (n_digits == 1) ? 9 : lo * 10 - 1;
        if (hi > VALUE_MAX) hi = VALUE_MAX;
        value = VALUE_W'($urandom_range(32'(hi), 32'(lo)));
      end
      two_digit = ($urandom_range(0, 2) == 0);
      send_value(value, two_digit);
    end
    s_axis_tvalid <= 1'b0;

    // Let the checker see the last handshake, then drain.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
